[src/breakpoint_match_table_assert.svh]
// Assertion macros for the breakpoint match table.
`ifndef BREAKPOINT_MATCH_TABLE_ASSERT_SVH
`define BREAKPOINT_MATCH_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BMT_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BMT_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
`else
`define BMT_ASSERT_IMPL(label, clk, rst, prop, msg)
`define BMT_ASSERT_NEXT(label, clk, rst, cond, nxt, msg)
`endif
`endif

[src/bmt_pkg.sv]
// Package with types and constants shared by the breakpoint match table.
package bmt_pkg;
   localparam int BpEntries = 16;
   localparam int IdxW = 4;
   localparam int CntW = 5;

   typedef enum logic [2:0] {
      MODE_ADD    = 3'd0,
      MODE_REMOVE = 3'd1,
      MODE_ENABLE = 3'd2,
      MODE_CHECK  = 3'd3,
      MODE_READ   = 3'd4
   } mode_type;

   localparam logic [2:0] KIND_FREE = 3'd0;
   localparam logic [2:0] KIND_MAX  = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_TRIM = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic trim;
   } cmd_type;

   typedef struct packed {
      logic trim_more;
   } status_type;
endpackage

[src/bmt_datapath.sv]
// Datapath of the breakpoint match table: slot registers, comparators, result register.
module bmt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bmt_pkg::cmd_type     cmd,
   output bmt_pkg::status_type  status,
   input  logic [2:0]           req_mode,
   input  logic signed [7:0]    req_module_number,
   input  logic [2:0]           req_breakpoint_type,
   input  logic signed [63:0]   req_address,
   input  logic [5:0]           req_size_log2,
   input  logic [3:0]           req_entry_index,
   input  logic                 req_enable_value,
   output logic                 rsp_ok,
   output logic                 rsp_hit,
   output logic [3:0]           rsp_hit_index,
   output logic                 rsp_entry_enabled,
   output logic [2:0]           rsp_entry_kind,
   output logic signed [63:0]   rsp_entry_base,
   output logic [63:0]          rsp_entry_addr_mask,
   output logic [63:0]          rsp_entry_modules,
   output logic                 rsp_any_enabled,
   output logic [4:0]           rsp_used_count
);
   import bmt_pkg::*;

   logic [2:0]  type_ff [BpEntries];
   logic        en_ff   [BpEntries];
   logic [63:0] base_ff [BpEntries];
   logic [63:0] mask_ff [BpEntries];
   logic [63:0] mods_ff [BpEntries];
   logic [CntW-1:0] hw_ff;
   logic        genb_ff;

   // Captured request, decoded once.
   logic [2:0]  mode_ff;
   logic [63:0] rmods_ff, rmask_ff, rbase_ff, radr_ff;
   logic [2:0]  kind_ff;
   logic [IdxW-1:0] idx_ff;
   logic        enb_ff;

   logic [63:0] mods_dec, mask_dec;
   always_comb begin
      if (req_module_number[7]) mods_dec = '1;
      else if (req_module_number[6]) mods_dec = '0;
      else mods_dec = 64'd1 << req_module_number[5:0];
      mask_dec = ~((64'd1 << req_size_log2) - 64'd1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         rmods_ff <= mods_dec;
         rmask_ff <= mask_dec;
         rbase_ff <= req_address & mask_dec;
         radr_ff  <= req_address;
         kind_ff  <= req_breakpoint_type;
         idx_ff   <= req_entry_index;
         enb_ff   <= req_enable_value;
      end
   end

   // Per-slot comparators.
   logic [BpEntries-1:0] live, exact, ovl, freev, hitv, anyen;
   always_comb begin
      for (int i = 0; i < BpEntries; i++) begin
         live[i]  = (CntW'(i) < hw_ff);
         exact[i] = live[i] && type_ff[i] == kind_ff && base_ff[i] == rbase_ff
                    && mask_ff[i] == rmask_ff;
         ovl[i]   = live[i] && type_ff[i] == kind_ff &&
                    (((rbase_ff & mask_ff[i]) == base_ff[i]) ||
                     ((base_ff[i] & rmask_ff) == rbase_ff));
         freev[i] = live[i] && type_ff[i] == KIND_FREE;
         hitv[i]  = live[i] && en_ff[i] && type_ff[i] == kind_ff &&
                    ((mods_ff[i] & rmods_ff) != 0) &&
                    ((radr_ff & mask_ff[i]) == base_ff[i]);
         anyen[i] = live[i] && en_ff[i];
      end
   end

   logic [IdxW-1:0] exact_i, free_i, hit_i;
   always_comb begin
      exact_i = '0; free_i = '0; hit_i = '0;
      for (int i = BpEntries - 1; i >= 0; i--) begin
         if (exact[i]) exact_i = IdxW'(i);
         if (freev[i]) free_i = IdxW'(i);
         if (hitv[i])  hit_i = IdxW'(i);
      end
   end

   logic idx_live, kind_ok;
   assign idx_live = (CntW'(idx_ff) < hw_ff);
   assign kind_ok  = kind_ff != KIND_FREE && kind_ff <= KIND_MAX;
   assign status.trim_more = hw_ff != '0 && type_ff[hw_ff[IdxW-1:0] - 1'b1] == KIND_FREE;

   logic [63:0] left_mods;
   assign left_mods = mods_ff[idx_ff] & ~rmods_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BpEntries; i++) begin
            type_ff[i] <= KIND_FREE; en_ff[i] <= 1'b0;
            base_ff[i] <= '0; mask_ff[i] <= '0; mods_ff[i] <= '0;
         end
         hw_ff   <= '0;
         genb_ff <= 1'b1;
         rsp_ok <= 1'b0; rsp_hit <= 1'b0; rsp_hit_index <= '0;
         rsp_entry_enabled <= 1'b0; rsp_entry_kind <= '0; rsp_entry_base <= '0;
         rsp_entry_addr_mask <= '0; rsp_entry_modules <= '0;
         rsp_any_enabled <= 1'b1; rsp_used_count <= '0;
      end else if (cmd.exec) begin
         rsp_ok <= 1'b0; rsp_hit <= 1'b0; rsp_hit_index <= '0;
         rsp_entry_enabled <= 1'b0; rsp_entry_kind <= '0; rsp_entry_base <= '0;
         rsp_entry_addr_mask <= '0; rsp_entry_modules <= '0;
         rsp_any_enabled <= genb_ff; rsp_used_count <= hw_ff;
         unique case (mode_ff)
            MODE_ADD: begin
               if (rmods_ff != 0 && kind_ok) begin
                  if (exact != '0) begin
                     mods_ff[exact_i] <= mods_ff[exact_i] | rmods_ff;
                     en_ff[exact_i] <= 1'b1;
                     genb_ff <= 1'b1; rsp_any_enabled <= 1'b1; rsp_ok <= 1'b1;
                  end else if (ovl == '0) begin
                     if (freev != '0 || hw_ff < CntW'(BpEntries)) begin
                        logic [IdxW-1:0] s;
                        s = (freev != '0) ? free_i : hw_ff[IdxW-1:0];
                        if (freev == '0) begin
                           hw_ff <= hw_ff + 1'b1;
                           rsp_used_count <= hw_ff + 1'b1;
                        end
                        type_ff[s] <= kind_ff; en_ff[s] <= 1'b1;
                        base_ff[s] <= rbase_ff; mask_ff[s] <= rmask_ff;
                        mods_ff[s] <= rmods_ff;
                        genb_ff <= 1'b1; rsp_any_enabled <= 1'b1; rsp_ok <= 1'b1;
                     end
                  end
               end
            end
            MODE_REMOVE: begin
               if (rmods_ff != 0 && idx_live && type_ff[idx_ff] != KIND_FREE) begin
                  rsp_ok <= 1'b1;
                  mods_ff[idx_ff] <= left_mods;
                  if (left_mods == 0) begin
                     type_ff[idx_ff] <= KIND_FREE; en_ff[idx_ff] <= 1'b0;
                     base_ff[idx_ff] <= '0; mask_ff[idx_ff] <= '0;
                  end
               end
            end
            MODE_ENABLE: begin
               if (idx_live) begin
                  logic [BpEntries-1:0] e;
                  e = anyen;
                  e[idx_ff] = enb_ff;
                  en_ff[idx_ff] <= enb_ff;
                  genb_ff <= e != '0; rsp_any_enabled <= e != '0; rsp_ok <= 1'b1;
               end
            end
            MODE_CHECK: begin
               if (genb_ff && rmods_ff != 0 && hitv != '0) begin
                  rsp_ok <= 1'b1; rsp_hit <= 1'b1; rsp_hit_index <= hit_i;
               end
            end
            MODE_READ: begin
               if (idx_live) begin
                  rsp_ok <= 1'b1;
                  rsp_entry_enabled <= en_ff[idx_ff];
                  rsp_entry_kind <= type_ff[idx_ff];
                  rsp_entry_base <= base_ff[idx_ff];
                  rsp_entry_addr_mask <= mask_ff[idx_ff];
                  rsp_entry_modules <= mods_ff[idx_ff];
               end
            end
            default: ;
         endcase
      end else if (cmd.trim) begin
         // Drop one trailing free slot per cycle.
         if (status.trim_more) begin
            hw_ff <= hw_ff - 1'b1;
            rsp_used_count <= hw_ff - 1'b1;
            if (hw_ff == CntW'(1)) begin
               genb_ff <= 1'b0; rsp_any_enabled <= 1'b0;
            end
         end
      end
   end
endmodule

[src/bmt_control.sv]
// Controller state machine of the breakpoint match table.
module bmt_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bmt_pkg::status_type status,
   output bmt_pkg::cmd_type    cmd
);
   import bmt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_TRIM;
         end
         ST_TRIM: begin
            cmd.trim = 1'b1;
            if (!status.trim_more) state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[src/breakpoint_match_table.sv]
// Top level of the breakpoint match table.
// Usage: the req_ channel carries one operation per transfer (add, remove
// module, set enable, check access, read entry); the rsp_ channel returns
// exactly one result per operation, in order.
// An operation is captured in the cycle of its transfer, executed against all
// sixteen slots in parallel in the next cycle, and then trailing free slots are
// trimmed from the high-water mark one per cycle. The result is offered the
// cycle after that, and a new request is taken the cycle after the result
// transfer, so one operation is finished before the next is accepted, as set
// by the single shared slot datapath and the trim loop.
// Reset is synchronous and active high; it frees every slot, clears the
// high-water mark and sets the global enable flag.
// When the receiver stalls, the result is held steady in its register and no
// new request is taken until the result transfer completes.
module breakpoint_match_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_mode,
   input  logic signed [7:0]   req_module_number,
   input  logic [2:0]          req_breakpoint_type,
   input  logic signed [63:0]  req_address,
   input  logic [5:0]          req_size_log2,
   input  logic [3:0]          req_entry_index,
   input  logic                req_enable_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_ok,
   output logic                rsp_hit,
   output logic [3:0]          rsp_hit_index,
   output logic                rsp_entry_enabled,
   output logic [2:0]          rsp_entry_kind,
   output logic signed [63:0]  rsp_entry_base,
   output logic [63:0]         rsp_entry_addr_mask,
   output logic [63:0]         rsp_entry_modules,
   output logic                rsp_any_enabled,
   output logic [4:0]          rsp_used_count
);
   import bmt_pkg::*;
`include "breakpoint_match_table_assert.svh"

   cmd_type    cmd;
   status_type status;

   bmt_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   bmt_datapath u_datapath (
      .clock, .reset, .cmd, .status,
      .req_mode, .req_module_number, .req_breakpoint_type, .req_address,
      .req_size_log2, .req_entry_index, .req_enable_value,
      .rsp_ok, .rsp_hit, .rsp_hit_index, .rsp_entry_enabled, .rsp_entry_kind,
      .rsp_entry_base, .rsp_entry_addr_mask, .rsp_entry_modules,
      .rsp_any_enabled, .rsp_used_count
   );

   // A result is never offered while a request can be taken.
   `BMT_ASSERT_IMPL(a_excl, clock, reset, !(req_ready && rsp_valid), "ready and valid both high")
   // An accepted request is executed in the next cycle.
   `BMT_ASSERT_NEXT(a_exec, clock, reset, req_valid && req_ready, cmd.exec, "load not followed by exec")
   // A hit always reports success.
   `BMT_ASSERT_IMPL(a_hit, clock, reset, rsp_valid && rsp_hit |-> rsp_ok, "hit without ok")
   // The high-water mark never exceeds the table size.
   `BMT_ASSERT_IMPL(a_cnt, clock, reset, rsp_used_count <= 5'd16, "used count too large")
endmodule
